// ===== design/slt_pkg.sv =====
// shared types, constants and helper functions of the source line tokenizer
package slt_pkg;

  // line geometry: positions saturate at MaxLine-1, lengths at MaxLine
  localparam int MaxLine = 1024;
  localparam int PosW    = $clog2(MaxLine);
  localparam int LenW    = PosW + 1;
  localparam logic [PosW-1:0] MaxPos = PosW'(MaxLine - 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxLine);

  // record queue between front and back
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = QPtrW + 1;

  // identifier keyword buffer, first character in the low byte
  localparam int KwChars = 5;
  localparam int KwW     = 8 * KwChars;

  // character codes
  localparam logic [7:0] ChLparen   = 8'h28;
  localparam logic [7:0] ChRparen   = 8'h29;
  localparam logic [7:0] ChLbracket = 8'h5b;
  localparam logic [7:0] ChRbracket = 8'h5d;
  localparam logic [7:0] ChLbrace   = 8'h7b;
  localparam logic [7:0] ChRbrace   = 8'h7d;
  localparam logic [7:0] ChPlus     = 8'h2b;
  localparam logic [7:0] ChStar     = 8'h2a;
  localparam logic [7:0] ChSlash    = 8'h2f;
  localparam logic [7:0] ChComma    = 8'h2c;
  localparam logic [7:0] ChMinus    = 8'h2d;
  localparam logic [7:0] ChColon    = 8'h3a;
  localparam logic [7:0] ChNewline  = 8'h0a;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChEq       = 8'h3d;
  localparam logic [7:0] ChLt       = 8'h3c;
  localparam logic [7:0] ChGt       = 8'h3e;
  localparam logic [7:0] ChQuote    = 8'h22;
  localparam logic [7:0] ChDot      = 8'h2e;
  localparam logic [7:0] ChUnder    = 8'h5f;

  typedef enum logic [4:0] {
    KIND_LPAREN     = 5'd0,
    KIND_RPAREN     = 5'd1,
    KIND_LBRACKET   = 5'd2,
    KIND_RBRACKET   = 5'd3,
    KIND_LBRACE     = 5'd4,
    KIND_RBRACE     = 5'd5,
    KIND_PLUS       = 5'd6,
    KIND_STAR       = 5'd7,
    KIND_SLASH      = 5'd8,
    KIND_COMMA      = 5'd9,
    KIND_MINUS      = 5'd10,
    KIND_COMPARE    = 5'd11,
    KIND_EQUAL      = 5'd12,
    KIND_LESS_EQUAL = 5'd13,
    KIND_LESS       = 5'd14,
    KIND_MORE_EQUAL = 5'd15,
    KIND_MORE       = 5'd16,
    KIND_STRING     = 5'd17,
    KIND_COLON      = 5'd18,
    KIND_NEWLINE    = 5'd19,
    KIND_NUMBER     = 5'd20,
    KIND_AND        = 5'd21,
    KIND_IF         = 5'd22,
    KIND_WHILE      = 5'd23,
    KIND_OR         = 5'd24,
    KIND_FOR        = 5'd25,
    KIND_TRUE       = 5'd26,
    KIND_FALSE      = 5'd27,
    KIND_IDENT      = 5'd28,
    KIND_UNKNOWN    = 5'd29
  } tok_kind_e;

  typedef enum logic [6:0] {
    MODE_IDLE  = 7'b0000001,
    MODE_IDENT = 7'b0000010,
    MODE_NUM   = 7'b0000100,
    MODE_STR   = 7'b0001000,
    MODE_PEQ   = 7'b0010000,
    MODE_PLT   = 7'b0100000,
    MODE_PGT   = 7'b1000000
  } scan_mode_e;

  typedef struct packed {
    tok_kind_e       kind;
    logic [PosW-1:0] start;
    logic [LenW-1:0] len;
  } token_t;

  // all tokens caused by one byte; t0 always valid, t1 only when two is set
  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } tok_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    scan_mode_e      mode;
    logic [PosW-1:0] pos;
  } front_stat_t;

  // keyword match, strings written reversed since the first char is the low byte
  function automatic tok_kind_e kw_kind(input logic [KwW-1:0] kw, input logic [LenW-1:0] len);
    tok_kind_e k;
    k = KIND_IDENT;
    if (len == LenW'(3) && kw == {16'h0000, "dna"}) k = KIND_AND;
    else if (len == LenW'(2) && kw == {24'h000000, "fi"}) k = KIND_IF;
    else if (len == LenW'(5) && kw == "elihw") k = KIND_WHILE;
    else if (len == LenW'(2) && kw == {24'h000000, "ro"}) k = KIND_OR;
    else if (len == LenW'(3) && kw == {16'h0000, "rof"}) k = KIND_FOR;
    else if (len == LenW'(4) && kw == {8'h00, "eurt"}) k = KIND_TRUE;
    else if (len == LenW'(5) && kw == "eslaf") k = KIND_FALSE;
    return k;
  endfunction

endpackage

// ===== design/source_line_tokenizer_top.sv =====
// top level of the source line tokenizer: front end, record queue, back end
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | char_code_i, line_end_i
//  out     | output    | out_valid_o/out_stall_i | token_kind_o, start_offset_o,
//          |           |                      | value_length_o, last_of_run_o
//
// - a byte is classified in the cycle it is accepted; its tokens reach the output
//   through the queue write and then the output register
// - one byte per cycle while in_stall_o is low and bytes give at most one token
//   each; the output register moves one token per cycle while out_stall_i is low,
//   so a byte that closes one token and opens another needs a second output word, absorbed by the 4-record queue
// - in_stall_o rises only when the record queue is full
// - reset clears the scan state, queue pointers and the output valid
// - out_stall_i holds the output register; the queue keeps filling behind it
module source_line_tokenizer_top import slt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      char_code_i,
  input  logic            line_end_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [4:0]      token_kind_o,
  output logic [PosW-1:0] start_offset_o,
  output logic [LenW-1:0] value_length_o,
  output logic            last_of_run_o
);

  // front to queue
  logic        rec_push;
  tok_rec_t    rec;
  front_stat_t fstat;

  // queue to back
  queue_stat_t qstat;
  tok_rec_t    head;
  logic        pop;

  // scanner: runs the per-byte state machine, writes one record per token-bearing byte
  slt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .line_end_i  (line_end_i),
    .qstat_i     (qstat),
    .rec_push_o  (rec_push),
    .rec_o       (rec),
    .stat_o      (fstat)
  );

  // record queue, lets the scanner keep going while the output side is held
  slt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (rec_push),
    .push_rec_i (rec),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  // output side, one token word per cycle unless out_stall_i holds it, with last_of_run on the final one
  slt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .qstat_i        (qstat),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .value_length_o (value_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  // the line's last byte closes everything and rewinds the position
  a_line_end_rewinds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && line_end_i |=> fstat.mode == MODE_IDLE && fstat.pos == '0)
    else $error("scan state not cleared after line end");

  // inside a line the position always moves forward from zero
  a_pos_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !line_end_i |=> fstat.pos != '0)
    else $error("line position did not advance");

  // the second token of a byte follows straight after the first
  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("token run broken before last_of_run");

endmodule

// ===== design/slt_front.sv =====
// tokenizer front end: scan state machine, turns each byte into a token record
module slt_front import slt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      char_code_i,
  input  logic            line_end_i,
  input  queue_stat_t     qstat_i,
  output logic            rec_push_o,
  output tok_rec_t        rec_o,
  output front_stat_t     stat_o
);

  scan_mode_e      mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] start_q, start_d;
  logic [LenW-1:0] len_q, len_d;
  logic [KwW-1:0]  kw_q, kw_d;

  logic            accept;
  logic [PosW-1:0] pos_inc;
  logic [LenW-1:0] len_inc;
  logic            is_dig, is_alp, is_idc;

  // fresh-byte handling
  logic            dsp_emit;
  token_t          dsp_tok;
  scan_mode_e      dsp_mode;
  logic [PosW-1:0] dsp_start;
  logic [LenW-1:0] dsp_len;
  logic [KwW-1:0]  dsp_kw;

  logic            first_emit;
  token_t          first_tok;
  logic            use_dsp;
  tok_kind_e       pend_single, pend_pair;

  assign accept     = in_valid_i && !qstat_i.full;
  assign in_stall_o = qstat_i.full;
  assign stat_o     = '{mode: mode_q, pos: pos_q};

  always_comb begin
    pos_inc = (pos_q == MaxPos) ? pos_q : pos_q + 1'b1;
    len_inc = (len_q == MaxLen) ? len_q : len_q + 1'b1;
    is_dig  = char_code_i inside {["0":"9"]};
    is_alp  = char_code_i inside {["a":"z"], ["A":"Z"]};
    is_idc  = is_dig || is_alp || (char_code_i == ChUnder);

    dsp_emit  = 1'b0;
    dsp_tok   = '{kind: KIND_UNKNOWN, start: pos_q, len: LenW'(1)};
    dsp_mode  = MODE_IDLE;
    dsp_start = start_q;
    dsp_len   = len_q;
    dsp_kw    = kw_q;
    if (is_dig) begin
      dsp_mode     = MODE_NUM;
      dsp_start    = pos_q;
      dsp_len      = LenW'(1);
      dsp_emit     = line_end_i;
      dsp_tok.kind = KIND_NUMBER;
    end else if (is_alp || char_code_i == ChUnder) begin
      dsp_mode     = MODE_IDENT;
      dsp_start    = pos_q;
      dsp_len      = LenW'(1);
      dsp_kw       = {{(KwW-8){1'b0}}, char_code_i};
      dsp_emit     = line_end_i;
      dsp_tok.kind = KIND_IDENT;
    end else begin
      case (char_code_i)
        ChLparen: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_LPAREN;
        end
        ChRparen: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_RPAREN;
        end
        ChLbracket: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_LBRACKET;
        end
        ChRbracket: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_RBRACKET;
        end
        ChLbrace: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_LBRACE;
        end
        ChRbrace: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_RBRACE;
        end
        ChPlus: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_PLUS;
        end
        ChStar: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_STAR;
        end
        ChSlash: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_SLASH;
        end
        ChComma: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_COMMA;
        end
        ChMinus: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_MINUS;
        end
        ChColon: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_COLON;
        end
        ChNewline: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_NEWLINE;
        end
        ChSpace, ChTab: begin
          dsp_emit = 1'b0;
        end
        ChEq, ChLt, ChGt: begin
          dsp_emit = line_end_i;
          if (char_code_i == ChEq) begin
            dsp_tok.kind = KIND_EQUAL;
            dsp_mode     = MODE_PEQ;
          end else if (char_code_i == ChLt) begin
            dsp_tok.kind = KIND_LESS;
            dsp_mode     = MODE_PLT;
          end else begin
            dsp_tok.kind = KIND_MORE;
            dsp_mode     = MODE_PGT;
          end
          dsp_start = pos_q;
          dsp_len   = LenW'(1);
        end
        ChQuote: begin
          dsp_mode  = MODE_STR;
          dsp_start = pos_inc;
          dsp_len   = '0;
          dsp_emit  = line_end_i;
          dsp_tok   = '{kind: KIND_STRING, start: pos_inc, len: '0};
        end
        default: begin
          dsp_emit = 1'b1; dsp_tok.kind = KIND_UNKNOWN;
        end
      endcase
    end

    // kinds of a pending comparison operator
    case (mode_q)
      MODE_PEQ: begin
        pend_single = KIND_EQUAL; pend_pair = KIND_COMPARE;
      end
      MODE_PLT: begin
        pend_single = KIND_LESS; pend_pair = KIND_LESS_EQUAL;
      end
      default: begin
        pend_single = KIND_MORE; pend_pair = KIND_MORE_EQUAL;
      end
    endcase

    first_emit = 1'b0;
    first_tok  = '{kind: KIND_IDENT, start: start_q, len: len_q};
    use_dsp    = 1'b0;
    mode_d     = mode_q;
    start_d    = start_q;
    len_d      = len_q;
    kw_d       = kw_q;

    case (mode_q)
      MODE_IDENT: begin
        if (is_idc) begin
          if (len_q < LenW'(KwChars)) kw_d[8*len_q[2:0] +: 8] = char_code_i;
          len_d          = len_inc;
          first_emit     = line_end_i;
          first_tok.kind = kw_kind(kw_d, len_d);
          first_tok.len  = len_d;
        end else begin
          first_emit     = 1'b1;
          first_tok.kind = kw_kind(kw_q, len_q);
          use_dsp        = 1'b1;
        end
      end
      MODE_NUM: begin
        first_tok.kind = KIND_NUMBER;
        if (is_dig || char_code_i == ChDot) begin
          len_d         = len_inc;
          first_emit    = line_end_i;
          first_tok.len = len_d;
        end else begin
          first_emit = 1'b1;
          use_dsp    = 1'b1;
        end
      end
      MODE_STR: begin
        first_tok.kind = KIND_STRING;
        if (char_code_i == ChQuote) begin
          first_emit = 1'b1;
          mode_d     = MODE_IDLE;
        end else begin
          len_d         = len_inc;
          first_emit    = line_end_i;
          first_tok.len = len_d;
        end
      end
      MODE_PEQ, MODE_PLT, MODE_PGT: begin
        first_emit = 1'b1;
        if (char_code_i == ChEq) begin
          first_tok.kind = pend_pair;
          first_tok.len  = LenW'(2);
          mode_d         = MODE_IDLE;
        end else begin
          first_tok.kind = pend_single;
          first_tok.len  = LenW'(1);
          use_dsp        = 1'b1;
        end
      end
      default: begin
        use_dsp = 1'b1;
      end
    endcase

    if (use_dsp) begin
      mode_d  = dsp_mode;
      start_d = dsp_start;
      len_d   = dsp_len;
      kw_d    = dsp_kw;
    end

    if (line_end_i) begin
      mode_d = MODE_IDLE;
      pos_d  = '0;
    end else begin
      pos_d  = pos_inc;
    end

    rec_o.two  = first_emit && use_dsp && dsp_emit;
    rec_o.t0   = first_emit ? first_tok : dsp_tok;
    rec_o.t1   = dsp_tok;
    rec_push_o = accept && (first_emit || (use_dsp && dsp_emit));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      kw_q    <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      kw_q    <= kw_d;
    end
  end

endmodule

// ===== design/slt_queue.sv =====
// short record queue that decouples the front end from the output side
module slt_queue import slt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tok_rec_t    push_rec_i,
  input  logic        pop_i,
  output tok_rec_t    head_o,
  output queue_stat_t stat_o
);

  tok_rec_t           slot_q [QueueDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QCntW-1:0]   cnt_q;

  assign stat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== design/slt_back.sv =====
// tokenizer back end: splits records into single words behind an output register
module slt_back import slt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  queue_stat_t     qstat_i,
  input  tok_rec_t        head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [4:0]      token_kind_o,
  output logic [PosW-1:0] start_offset_o,
  output logic [LenW-1:0] value_length_o,
  output logic            last_of_run_o
);

  logic   valid_q;
  token_t tok_q, tok_d;
  logic   last_q, last_d;
  logic   second_q, second_d;
  logic   load, take;

  assign load = !valid_q || !out_stall_i;
  assign take = load && !qstat_i.empty;

  always_comb begin
    if (second_q) begin
      tok_d    = head_i.t1;
      last_d   = 1'b1;
      second_d = 1'b0;
    end else begin
      tok_d    = head_i.t0;
      last_d   = !head_i.two;
      second_d = head_i.two;
    end
    pop_o = take && (second_q || !head_i.two);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load) begin
      valid_q  <= !qstat_i.empty;
      if (take) second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_q  <= tok_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign token_kind_o   = tok_q.kind;
  assign start_offset_o = tok_q.start;
  assign value_length_o = tok_q.len;
  assign last_of_run_o  = last_q;

endmodule
